### src/kmerh_pkg.sv
// kmerh_pkg: widths, symbol codes and result type for the k-mer hash encoder.
// No dependencies; every other file of the block imports it.
`default_nettype none

package kmerh_pkg;

  // Field widths
  localparam int SymW  = 8;   // ASCII symbol
  localparam int CodeW = 2;   // two-bit nucleotide code
  localparam int AccW  = 32;  // forward / revcomp accumulators
  localparam int OffW  = 31;  // length offset (4^L-4)/3
  localparam int HashW = 33;  // accumulator plus offset
  localparam int CntW  = 5;   // length count

  // ASCII letters
  localparam logic [SymW-1:0] ChUpA = 8'h41;
  localparam logic [SymW-1:0] ChUpC = 8'h43;
  localparam logic [SymW-1:0] ChUpG = 8'h47;
  localparam logic [SymW-1:0] ChUpT = 8'h54;
  localparam logic [SymW-1:0] ChLoA = 8'h61;
  localparam logic [SymW-1:0] ChLoC = 8'h63;
  localparam logic [SymW-1:0] ChLoG = 8'h67;
  localparam logic [SymW-1:0] ChLoT = 8'h74;

  // Nucleotide codes
  localparam logic [CodeW-1:0] CodeA = 2'd0;
  localparam logic [CodeW-1:0] CodeC = 2'd1;
  localparam logic [CodeW-1:0] CodeG = 2'd2;
  localparam logic [CodeW-1:0] CodeT = 2'd3;

  // Offset step: offset*4 + 4 for each symbol after the first
  localparam logic [OffW-1:0] OffStep = 31'd4;

  typedef struct packed {
    logic             ok;
    logic [CodeW-1:0] code;
  } sym_dec_t;

  typedef struct packed {
    logic [HashW-1:0] forward_hash;
    logic [HashW-1:0] revcomp_hash;
    logic [CntW-1:0]  seq_length;
    logic             bad_symbol;
    logic             too_long;
  } result_t;

  // Map a character to its code; anything else is flagged and coded as A.
  function automatic sym_dec_t decode_sym(input logic [SymW-1:0] ch);
    sym_dec_t d;
    d.ok   = 1'b1;
    d.code = CodeA;
    unique case (ch)
      ChUpA, ChLoA: d.code = CodeA;
      ChUpC, ChLoC: d.code = CodeC;
      ChUpG, ChLoG: d.code = CodeG;
      ChUpT, ChLoT: d.code = CodeT;
      default: begin
        d.ok   = 1'b0;
        d.code = CodeA;
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### src/kmerh_ifs.sv
// kmerh_ifs: valid/ready channel interfaces for symbols in and hash results out.
// Depends on kmerh_pkg for field widths.
`default_nettype none

interface kmerh_sym_if import kmerh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last;

  modport source(output valid, symbol, last, input ready);
  modport sink(input valid, symbol, last, output ready);
endinterface

interface kmerh_res_if import kmerh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HashW-1:0] forward_hash;
  logic [HashW-1:0] revcomp_hash;
  logic [CntW-1:0]  seq_length;
  logic             bad_symbol;
  logic             too_long;

  modport source(output valid, forward_hash, revcomp_hash, seq_length, bad_symbol,
                 too_long, input ready);
  modport sink(input valid, forward_hash, revcomp_hash, seq_length, bad_symbol,
               too_long, output ready);
endinterface

`default_nettype wire

### src/kmerh_acc.sv
// kmerh_acc: forward / reverse-complement accumulators, length count and offset.
// Depends on kmerh_pkg; produces the result of the current item combinationally.
`default_nettype none

module kmerh_acc import kmerh_pkg::*; #(
  parameter int MAX_LEN = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            take,
  input  wire logic [SymW-1:0] symbol,
  input  wire logic            last,
  output result_t              res
);

  localparam logic [CntW-1:0] MaxLenC = CntW'(MAX_LEN);

  logic [AccW-1:0]  fwd_r, fwd_nxt, fwd_upd;
  logic [AccW-1:0]  rc_r, rc_nxt, rc_upd;
  logic [OffW-1:0]  off_r, off_nxt, off_upd;
  logic [CntW-1:0]  cnt_r, cnt_nxt, cnt_upd;
  logic             bad_r, bad_nxt, bad_upd;
  logic             ovf_r, ovf_nxt, ovf_upd;
  sym_dec_t         dec;
  logic [CodeW-1:0] inv_code;
  logic [AccW-1:0]  rc_ins;

  // Per-item update; symbols past the maximum length are dropped unchecked
  always_comb begin
    dec      = decode_sym(symbol);
    inv_code = ~dec.code;
    rc_ins   = {{(AccW-CodeW){1'b0}}, inv_code};
    fwd_upd  = fwd_r;
    rc_upd   = rc_r;
    off_upd  = off_r;
    cnt_upd  = cnt_r;
    bad_upd  = bad_r;
    ovf_upd  = ovf_r;
    if (cnt_r >= MaxLenC) begin
      ovf_upd = 1'b1;
    end else begin
      if (!dec.ok) begin
        bad_upd = 1'b1;
      end
      fwd_upd = {fwd_r[AccW-CodeW-1:0], dec.code};
      // shift of 32 or more places nothing
      rc_upd  = rc_r | (rc_ins << {cnt_r, 1'b0});
      if (cnt_r != '0) begin
        off_upd = {off_r[OffW-3:0], 2'b00} + OffStep;
      end
      cnt_upd = cnt_r + 1'b1;
    end
  end

  // Result seen on the final symbol
  always_comb begin
    res.forward_hash = {1'b0, fwd_upd} + {2'b00, off_upd};
    res.revcomp_hash = {1'b0, rc_upd} + {2'b00, off_upd};
    res.seq_length   = cnt_upd;
    res.bad_symbol   = bad_upd;
    res.too_long     = ovf_upd;
  end

  // Next state: hold, update, or clear after the final symbol
  always_comb begin
    fwd_nxt = fwd_r;
    rc_nxt  = rc_r;
    off_nxt = off_r;
    cnt_nxt = cnt_r;
    bad_nxt = bad_r;
    ovf_nxt = ovf_r;
    if (take) begin
      if (last) begin
        fwd_nxt = '0;
        rc_nxt  = '0;
        off_nxt = '0;
        cnt_nxt = '0;
        bad_nxt = 1'b0;
        ovf_nxt = 1'b0;
      end else begin
        fwd_nxt = fwd_upd;
        rc_nxt  = rc_upd;
        off_nxt = off_upd;
        cnt_nxt = cnt_upd;
        bad_nxt = bad_upd;
        ovf_nxt = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
      rc_r  <= '0;
      off_r <= '0;
      cnt_r <= '0;
      bad_r <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      fwd_r <= fwd_nxt;
      rc_r  <= rc_nxt;
      off_r <= off_nxt;
      cnt_r <= cnt_nxt;
      bad_r <= bad_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Count never passes the maximum length
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MaxLenC)
    else $error("kmerh_acc: length count above maximum");

  // Overflow is only possible with a full count
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == MaxLenC))
    else $error("kmerh_acc: overflow flag without full count");

  // Offset stays zero until a second symbol arrives
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= 5'd1) |-> (off_r == '0))
    else $error("kmerh_acc: nonzero offset for short sequence");

endmodule

`default_nettype wire

### src/kmerh_obuf.sv
// kmerh_obuf: output register plus one skid entry for hash results.
// Depends on kmerh_pkg and kmerh_res_if.
`default_nettype none

module kmerh_obuf import kmerh_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         can_push,
  kmerh_res_if.source  out_ch
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop      = out_valid_r && out_ch.ready;
  assign can_push = !skid_valid_r;

  // Refill the output from the skid entry first, then from a new item
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = push;
      out_data_nxt  = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.forward_hash = out_data_r.forward_hash;
  assign out_ch.revcomp_hash = out_data_r.revcomp_hash;
  assign out_ch.seq_length   = out_data_r.seq_length;
  assign out_ch.bad_symbol   = out_data_r.bad_symbol;
  assign out_ch.too_long     = out_data_r.too_long;

  // Skid entry is only used behind a held output
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("kmerh_obuf: skid entry without output entry");

  // No push into a full buffer
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("kmerh_obuf: push while full");

  // A taken output drains the skid entry into the output
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ch.ready) |=> (!skid_valid_r && out_valid_r))
    else $error("kmerh_obuf: skid entry not moved up");

endmodule

`default_nettype wire

### src/kmer_hash_encoder.sv
// kmer_hash_encoder takes one ASCII nucleotide per cycle while in_ch.ready is
// high on in_ch (A, C, G, T in either case) and, on the item marked last,
// returns on out_ch the forward and reverse-complement two-bit hashes of the
// sequence, each plus the length offset (4^L-4)/3, together with the length
// and the bad_symbol / too_long flags. The accumulators update when an item is
// accepted; a last item's result is registered into the output register, or
// into the one skid entry while the output is held. The two let symbols keep
// flowing while a result waits; in_ch.ready drops only when both hold unread
// results. Symbols beyond MAX_LEN are dropped and flagged too_long.
// Depends on kmerh_pkg, kmerh_ifs, kmerh_acc and kmerh_obuf.
`default_nettype none

module kmer_hash_encoder import kmerh_pkg::*; #(
  parameter int MAX_LEN = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  kmerh_sym_if.sink   in_ch,
  kmerh_res_if.source out_ch
);

  logic    in_take;
  logic    can_push;
  result_t res;

  // Accept whenever the output side has a free entry
  assign in_ch.ready = can_push;
  assign in_take     = in_ch.valid && can_push;

  kmerh_acc #(
    .MAX_LEN(MAX_LEN)
  ) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take),
    .symbol(in_ch.symbol),
    .last  (in_ch.last),
    .res   (res)
  );

  kmerh_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_take && in_ch.last),
    .push_data(res),
    .can_push (can_push),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

### test/kmer_hash_encoder_tb.sv
// kmer_hash_encoder_tb: self-checking bench for the k-mer hash encoder, directed table then
// random nucleotide sequences under three sender/receiver stall mixes.
// Depends on kmerh_pkg, kmerh_ifs and the kmer_hash_encoder RTL.
`default_nettype none

module kmer_hash_encoder_tb;
  import kmerh_pkg::*;

  localparam int MaxLen     = 16;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 550;
  localparam int DrainWait  = 10;

  typedef struct {
    logic [SymW-1:0] sym;
    logic            last;
    logic            typed;   // res holds a hand-written expectation
    result_t         res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  kmerh_sym_if sym_ch ();
  kmerh_res_if res_ch ();

  kmer_hash_encoder #(.MAX_LEN(MaxLen)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (sym_ch),
    .out_ch(res_ch)
  );

  // Sequence state of the predictor
  logic [AccW-1:0] kmer_fwd;
  logic [AccW-1:0] kmer_rc;
  logic [OffW-1:0] len_off;
  logic [CntW-1:0] base_cnt;
  logic            saw_bad;
  logic            saw_overflow;

  result_t   hash_q[$];
  dir_row_t  dir_tab[$];
  int        errors;
  int        stall_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;
  result_t   want;

  function automatic void clear_seq();
    kmer_fwd     = '0;
    kmer_rc      = '0;
    len_off      = '0;
    base_cnt     = '0;
    saw_bad      = 1'b0;
    saw_overflow = 1'b0;
  endfunction

  // Fold one character into the running hashes; returns 1 when it closes a sequence.
  function automatic bit absorb_base(input logic [SymW-1:0] sym, input logic last,
                                     output result_t r);
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] comp;
    int               shift;
    r = '0;
    if (base_cnt >= MaxLen) begin
      saw_overflow = 1'b1;
    end else begin
      code = CodeA;
      case (sym)
        ChUpA, ChLoA: code = CodeA;
        ChUpC, ChLoC: code = CodeC;
        ChUpG, ChLoG: code = CodeG;
        ChUpT, ChLoT: code = CodeT;
        default:      saw_bad = 1'b1;
      endcase
      kmer_fwd = {kmer_fwd[AccW-3:0], code};
      comp     = CodeT - code;
      shift    = 2 * base_cnt;
      if (shift < AccW) kmer_rc = kmer_rc | ({{(AccW-CodeW){1'b0}}, comp} << shift);
      if (base_cnt != 0) len_off = (len_off << 2) + OffStep;
      base_cnt = base_cnt + 1'b1;
    end
    if (!last) return 1'b0;
    r.forward_hash = {1'b0, kmer_fwd} + {2'b00, len_off};
    r.revcomp_hash = {1'b0, kmer_rc} + {2'b00, len_off};
    r.seq_length   = base_cnt;
    r.bad_symbol   = saw_bad;
    r.too_long     = saw_overflow;
    clear_seq();
    return 1'b1;
  endfunction

  function automatic result_t make_res(input logic [HashW-1:0] fh, input logic [HashW-1:0] rh,
                                       input logic [CntW-1:0] len, input logic bad,
                                       input logic over);
    result_t r;
    r.forward_hash = fh;
    r.revcomp_hash = rh;
    r.seq_length   = len;
    r.bad_symbol   = bad;
    r.too_long     = over;
    return r;
  endfunction

  function automatic dir_row_t make_row(input logic [SymW-1:0] sym, input logic last,
                                        input logic typed, input result_t res);
    dir_row_t row;
    row.sym   = sym;
    row.last  = last;
    row.typed = typed;
    row.res   = res;
    return row;
  endfunction

  function automatic logic [SymW-1:0] pick_base();
    case ($urandom_range(7))
      0: return ChUpA;
      1: return ChUpC;
      2: return ChUpG;
      3: return ChUpT;
      4: return ChLoA;
      5: return ChLoC;
      6: return ChLoG;
      default: return ChLoT;
    endcase
  endfunction

  // Present one item from a falling edge; return at the falling edge after it is taken.
  task automatic feed(input logic [SymW-1:0] sym, input logic last, input logic typed,
                      input result_t res);
    result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      sym_ch.valid = 1'b0;
      @(negedge clk);
    end
    sym_ch.valid  = 1'b1;
    sym_ch.symbol = sym;
    sym_ch.last   = last;
    do @(posedge clk); while (!sym_ch.ready);
    if (absorb_base(sym, last, got)) hash_q.push_back(typed ? res : got);
    @(negedge clk);
  endtask

  // Random sequences: mostly clean letters, some bad bytes, some overlong runs.
  task automatic run_sequences(input int n_items);
    int      sent;
    int      len;
    int      pick;
    logic [SymW-1:0] sym;
    result_t none;
    sent = 0;
    none = '0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80)      len = $urandom_range(MaxLen, 1);
      else if (pick < 88) len = MaxLen;
      else                len = $urandom_range(MaxLen + 4, MaxLen + 1);
      for (int i = 0; i < len; i++) begin
        sym = ($urandom_range(99) < 93) ? pick_base() : 8'($urandom_range(255));
        feed(sym, i == len - 1, 1'b0, none);
      end
      sent += len;
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result-side backpressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (hash_q.size() == 0) begin
        $display("%0t: result with none expected: fwd %h rc %h len %0d", $time,
                 res_ch.forward_hash, res_ch.revcomp_hash, res_ch.seq_length);
        errors++;
      end else begin
        want = hash_q.pop_front();
        if (res_ch.forward_hash !== want.forward_hash) begin
          $display("%0t: forward_hash exp %h got %h", $time, want.forward_hash,
                   res_ch.forward_hash);
          errors++;
        end
        if (res_ch.revcomp_hash !== want.revcomp_hash) begin
          $display("%0t: revcomp_hash exp %h got %h", $time, want.revcomp_hash,
                   res_ch.revcomp_hash);
          errors++;
        end
        if (res_ch.seq_length !== want.seq_length) begin
          $display("%0t: seq_length exp %0d got %0d", $time, want.seq_length,
                   res_ch.seq_length);
          errors++;
        end
        if (res_ch.bad_symbol !== want.bad_symbol) begin
          $display("%0t: bad_symbol exp %b got %b", $time, want.bad_symbol,
                   res_ch.bad_symbol);
          errors++;
        end
        if (res_ch.too_long !== want.too_long) begin
          $display("%0t: too_long exp %b got %b", $time, want.too_long, res_ch.too_long);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    rst_n         = 1'b0;
    sym_ch.valid  = 1'b0;
    sym_ch.symbol = '0;
    sym_ch.last   = 1'b0;
    errors        = 0;
    stall_cycles  = 0;
    send_idle_pct = 28;
    recv_idle_pct = 54;
    clear_seq();

    // Singles, bad bytes at both ends of the range, a mixed-case run, then an
    // all-T run of full length plus one dropped byte (too long, not bad).
    dir_tab.push_back(make_row(ChUpA, 1'b1, 1'b1, make_res(33'd0, 33'd3, 5'd1, 1'b0, 1'b0)));
    dir_tab.push_back(make_row(ChLoT, 1'b1, 1'b1, make_res(33'd3, 33'd0, 5'd1, 1'b0, 1'b0)));
    dir_tab.push_back(make_row(8'h00, 1'b1, 1'b1, make_res(33'd0, 33'd3, 5'd1, 1'b1, 1'b0)));
    dir_tab.push_back(make_row(8'hFF, 1'b1, 1'b1, make_res(33'd0, 33'd3, 5'd1, 1'b1, 1'b0)));
    dir_tab.push_back(make_row(ChUpC, 1'b0, 1'b0, '0));
    dir_tab.push_back(make_row(ChLoG, 1'b0, 1'b0, '0));
    dir_tab.push_back(make_row(ChLoA, 1'b0, 1'b0, '0));
    dir_tab.push_back(make_row(ChUpG, 1'b1, 1'b0, '0));
    for (int i = 0; i < MaxLen; i++) dir_tab.push_back(make_row(ChUpT, 1'b0, 1'b0, '0));
    dir_tab.push_back(make_row(8'h00, 1'b1, 1'b1,
                               make_res(33'h1_5555_5553, 33'h0_5555_5554, 5'd16, 1'b0, 1'b1)));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) feed(dir_tab[i].sym, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].res);

    run_sequences(PhaseItems);
    send_idle_pct = 54;
    recv_idle_pct = 28;
    run_sequences(PhaseItems);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_sequences(PhaseItems);
    sym_ch.valid = 1'b0;

    while (hash_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/kmerh_pkg.sv
src/kmerh_ifs.sv
src/kmerh_acc.sv
src/kmerh_obuf.sv
src/kmer_hash_encoder.sv
test/kmer_hash_encoder_tb.sv
